FILE: hw/rtl/salc_pkg.sv
// Shared constants and types for the set-associative LRU write-back cache core.
// No dependencies; used by salc_ram, set_assoc_lru_writeback_cache_core and the testbench files.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  // Field widths
  localparam int BLOCK_W   = 31;           // memory block number
  localparam int WAYS_W    = 4;            // ways register
  localparam int SETS_W    = 9;            // set count register
  localparam int CFG_W     = 9;            // config write data, widest register
  localparam int CFG_IDX_W = 1;            // config register index
  localparam int DIVR_W    = SETS_W + 1;   // divider partial remainder
  localparam int CNT_W     = $clog2(BLOCK_W);

  // Default geometry
  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_MAX_SETS = 256;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_Q,    // block / ways, one quotient bit a cycle
    S_DIV_S,    // quotient mod sets, same divider
    S_META,     // row read issued
    S_CAPT,     // row captured, first tag read issued
    S_WALK,     // one way a cycle
    S_UPD,      // row write; on a miss, tag write and first result
    S_FETCH     // fetch after a write-back
  } state_t;

endpackage : salc_pkg

`default_nettype wire

FILE: hw/rtl/salc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on salc_pkg for parameter defaults only.
`timescale 1ns / 1ps
`default_nettype none

module salc_ram #(
  parameter int WIDTH = salc_pkg::BLOCK_W,
  parameter int DEPTH = salc_pkg::DEF_MAX_SETS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : salc_ram

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_writeback_cache_core.sv
// Set-associative LRU write-back cache core. A request divides the block by the ways and the
// quotient by the set count, reads the set's row, walks the ways in use and updates the row;
// a miss issues a fetch, after a write-back if the victim is dirty; a hit issues no result.
// The shared restoring divider (one bit a cycle) and the single tag read port set its pace.
// One request at a time; busy is high from acceptance until the last result, if any, is issued.
// Results are strobed for one cycle; the receiver cannot stall. Synchronous reset clears
// ways and set count to 1 and all lines invalid; a config write also invalidates every line.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_writeback_cache_core #(
  parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = salc_pkg::DEF_MAX_SETS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_req_type,
  input  wire logic [salc_pkg::BLOCK_W-1:0]      in_block_number,
  // result channel
  output logic                                   out_valid,
  output logic                                   out_mem_write,
  output logic      [salc_pkg::BLOCK_W-1:0]      out_mem_block,
  output logic                                   out_last,
  // config write port
  input  wire logic                              cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [salc_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int LINES   = MAX_SETS * MAX_WAYS;
  localparam int LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int BW      = salc_pkg::BLOCK_W;
  localparam int SW      = salc_pkg::SETS_W;
  localparam int RW      = salc_pkg::DIVR_W;
  localparam int CW      = salc_pkg::CNT_W;

  typedef struct packed {
    logic             v;
    logic             d;
    logic [AGE_W-1:0] age;
  } way_meta_t;

  localparam int ROW_W = MAX_WAYS * $bits(way_meta_t);

  // registers
  salc_pkg::state_t                   state_r, state_nxt;
  logic [salc_pkg::WAYS_W-1:0]        ways_r;
  logic [SW-1:0]                      sets_r;
  logic [MAX_SETS-1:0]                row_ok_r, row_ok_nxt;
  logic                               req_wr_r, req_wr_nxt;
  logic [BW-1:0]                      blk_r, blk_nxt;
  logic [BW-1:0]                      sh_r, sh_nxt;
  logic [RW-1:0]                      rem_r, rem_nxt;
  logic [SW-1:0]                      div_r, div_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic [SET_W-1:0]                   set_r, set_nxt;
  way_meta_t [MAX_WAYS-1:0]           meta_r, meta_nxt;
  logic [WAY_W-1:0]                   walk_r, walk_nxt;
  logic                               hit_r, hit_nxt;
  logic [WAY_W-1:0]                   hit_way_r, hit_way_nxt;
  logic                               free_r, free_nxt;
  logic [WAY_W-1:0]                   free_way_r, free_way_nxt;
  logic                               old_seen_r, old_seen_nxt;
  logic [WAY_W-1:0]                   old_way_r, old_way_nxt;
  logic [AGE_W-1:0]                   old_age_r, old_age_nxt;
  logic [BW-1:0]                      old_tag_r, old_tag_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_write_r, out_write_nxt;
  logic [BW-1:0]                      out_block_r, out_block_nxt;
  logic                               out_last_r, out_last_nxt;

  // memory ports
  logic                               meta_rd_en, meta_we;
  logic [ROW_W-1:0]                   meta_rd_data, meta_wdata;
  logic                               tag_rd_en, tag_we;
  logic [LINE_AW-1:0]                 tag_rd_addr, tag_wr_addr;
  logic [BW-1:0]                      tag_rd_data;

  // clamped geometry
  logic [salc_pkg::WAYS_W-1:0]        nw_eff;
  logic [SW-1:0]                      ns_eff;

  // shared divider step
  logic [RW-1:0]                      rem_sh;
  logic                               div_ge;
  logic [RW-1:0]                      rem_step;
  logic [BW-1:0]                      sh_step;

  function automatic logic [LINE_AW-1:0] line_addr(input logic [SET_W-1:0] s,
                                                   input logic [WAY_W-1:0] w);
    line_addr = LINE_AW'(32'(s) * MAX_WAYS + 32'(w));
  endfunction

  assign nw_eff = (ways_r == '0) ? salc_pkg::WAYS_W'(1) :
                  (32'(ways_r) > MAX_WAYS) ? salc_pkg::WAYS_W'(MAX_WAYS) : ways_r;
  assign ns_eff = (sets_r == '0) ? SW'(1) :
                  (32'(sets_r) > MAX_SETS) ? SW'(MAX_SETS) : sets_r;

  // restoring division, one bit per cycle
  assign rem_sh   = {rem_r[RW-2:0], sh_r[BW-1]};
  assign div_ge   = rem_sh >= {1'b0, div_r};
  assign rem_step = div_ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
  assign sh_step  = {sh_r[BW-2:0], div_ge};

  assign busy          = (state_r != salc_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_mem_write = out_write_r;
  assign out_mem_block = out_block_r;
  assign out_last      = out_last_r;

  // line memories
  salc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_meta_ram (
    .clk     (clk),
    .we      (meta_we),
    .wr_addr (set_r),
    .wr_data (meta_wdata),
    .rd_en   (meta_rd_en),
    .rd_addr (set_r),
    .rd_data (meta_rd_data)
  );

  salc_ram #(.WIDTH(BW), .DEPTH(LINES)) u_tag_ram (
    .clk     (clk),
    .we      (tag_we),
    .wr_addr (tag_wr_addr),
    .wr_data (blk_r),
    .rd_en   (tag_rd_en),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_rd_data)
  );

  // sequencer: next state, datapath and memory controls
  always_comb begin
    way_meta_t        cur;
    way_meta_t        m;
    logic [WAY_W-1:0] slot;
    logic             full;
    logic             wb;
    logic [AGE_W-1:0] hit_age;

    state_nxt     = state_r;
    row_ok_nxt    = row_ok_r;
    req_wr_nxt    = req_wr_r;
    blk_nxt       = blk_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    set_nxt       = set_r;
    meta_nxt      = meta_r;
    walk_nxt      = walk_r;
    hit_nxt       = hit_r;
    hit_way_nxt   = hit_way_r;
    free_nxt      = free_r;
    free_way_nxt  = free_way_r;
    old_seen_nxt  = old_seen_r;
    old_way_nxt   = old_way_r;
    old_age_nxt   = old_age_r;
    old_tag_nxt   = old_tag_r;
    out_valid_nxt = 1'b0;
    out_write_nxt = out_write_r;
    out_block_nxt = out_block_r;
    out_last_nxt  = out_last_r;
    meta_rd_en    = 1'b0;
    meta_we       = 1'b0;
    meta_wdata    = meta_r;
    tag_rd_en     = 1'b0;
    tag_we        = 1'b0;
    tag_rd_addr   = line_addr(set_r, WAY_W'(walk_r + 1'b1));
    cur           = meta_r[walk_r];
    m             = '0;
    full          = !hit_r && !free_r;
    slot          = hit_r ? hit_way_r : (free_r ? free_way_r : old_way_r);
    wb            = full && meta_r[old_way_r].d;
    hit_age       = meta_r[hit_way_r].age;
    tag_wr_addr   = line_addr(set_r, slot);

    case (state_r)
      salc_pkg::S_IDLE: begin
        if (start) begin
          req_wr_nxt = in_req_type;
          blk_nxt    = in_block_number;
          sh_nxt     = in_block_number;
          rem_nxt    = '0;
          div_nxt    = SW'(nw_eff);
          cnt_nxt    = '0;
          state_nxt  = salc_pkg::S_DIV_Q;
        end
      end

      salc_pkg::S_DIV_Q: begin
        sh_nxt  = sh_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == BW - 1) begin
          // quotient now in the shift register; reduce it modulo the set count
          rem_nxt   = '0;
          div_nxt   = ns_eff;
          cnt_nxt   = '0;
          state_nxt = salc_pkg::S_DIV_S;
        end
      end

      salc_pkg::S_DIV_S: begin
        sh_nxt  = sh_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == BW - 1) begin
          set_nxt   = SET_W'(rem_step);
          state_nxt = salc_pkg::S_META;
        end
      end

      salc_pkg::S_META: begin
        meta_rd_en = 1'b1;
        state_nxt  = salc_pkg::S_CAPT;
      end

      salc_pkg::S_CAPT: begin
        // a row never written since the last clear reads as all invalid
        meta_nxt     = row_ok_r[set_r] ? meta_rd_data : '0;
        tag_rd_en    = 1'b1;
        tag_rd_addr  = line_addr(set_r, '0);
        walk_nxt     = '0;
        hit_nxt      = 1'b0;
        free_nxt     = 1'b0;
        old_seen_nxt = 1'b0;
        state_nxt    = salc_pkg::S_WALK;
      end

      salc_pkg::S_WALK: begin
        tag_rd_en = 1'b1;
        if (cur.v) begin
          if (!hit_r && tag_rd_data == blk_r) begin
            hit_nxt     = 1'b1;
            hit_way_nxt = walk_r;
          end
          if (!old_seen_r || cur.age >= old_age_r) begin
            old_seen_nxt = 1'b1;
            old_way_nxt  = walk_r;
            old_age_nxt  = cur.age;
            old_tag_nxt  = tag_rd_data;
          end
        end else if (!free_r) begin
          free_nxt     = 1'b1;
          free_way_nxt = walk_r;
        end
        walk_nxt = walk_r + 1'b1;
        if (32'(walk_r) + 1 >= 32'(nw_eff)) begin
          state_nxt = salc_pkg::S_UPD;
        end
      end

      salc_pkg::S_UPD: begin
        // LRU and dirty update for the whole row
        for (int w = 0; w < MAX_WAYS; w++) begin
          m = meta_r[w];
          if (hit_r) begin
            if (m.v && m.age < hit_age) m.age = m.age + 1'b1;
          end else begin
            if (full && WAY_W'(w) == old_way_r) m.v = 1'b0;
            if (m.v) m.age = m.age + 1'b1;
          end
          if (WAY_W'(w) == slot) begin
            m.v   = 1'b1;
            m.age = '0;
            m.d   = hit_r ? (m.d | req_wr_r) : req_wr_r;
          end
          meta_wdata[w*$bits(way_meta_t) +: $bits(way_meta_t)] = m;
        end
        meta_we            = 1'b1;
        row_ok_nxt[set_r]  = 1'b1;
        tag_we             = !hit_r;
        state_nxt          = salc_pkg::S_IDLE;
        if (!hit_r) begin
          out_valid_nxt = 1'b1;
          if (wb) begin
            out_write_nxt = 1'b1;
            out_block_nxt = old_tag_r;
            out_last_nxt  = 1'b0;
            state_nxt     = salc_pkg::S_FETCH;
          end else begin
            out_write_nxt = 1'b0;
            out_block_nxt = blk_r;
            out_last_nxt  = 1'b1;
          end
        end
      end

      salc_pkg::S_FETCH: begin
        out_valid_nxt = 1'b1;
        out_write_nxt = 1'b0;
        out_block_nxt = blk_r;
        out_last_nxt  = 1'b1;
        state_nxt     = salc_pkg::S_IDLE;
      end

      default: begin
        state_nxt = salc_pkg::S_IDLE;
      end
    endcase

    // any register write drops every line
    if (cfg_we) begin
      row_ok_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salc_pkg::S_IDLE;
      ways_r      <= salc_pkg::WAYS_W'(1);
      sets_r      <= SW'(1);
      row_ok_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_ok_r    <= row_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          salc_pkg::CFG_WAYS: ways_r <= cfg_wdata[salc_pkg::WAYS_W-1:0];
          salc_pkg::CFG_SETS: sets_r <= cfg_wdata[SW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    req_wr_r    <= req_wr_nxt;
    blk_r       <= blk_nxt;
    sh_r        <= sh_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    cnt_r       <= cnt_nxt;
    set_r       <= set_nxt;
    meta_r      <= meta_nxt;
    walk_r      <= walk_nxt;
    hit_r       <= hit_nxt;
    hit_way_r   <= hit_way_nxt;
    free_r      <= free_nxt;
    free_way_r  <= free_way_nxt;
    old_seen_r  <= old_seen_nxt;
    old_way_r   <= old_way_nxt;
    old_age_r   <= old_age_nxt;
    old_tag_r   <= old_tag_nxt;
    out_write_r <= out_write_nxt;
    out_block_r <= out_block_nxt;
    out_last_r  <= out_last_nxt;
  end

  // checks
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == salc_pkg::S_UPD || $past(state_r) == salc_pkg::S_FETCH))
    else $error("result strobe without an update or fetch step");

  a_wb_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && out_last && !out_mem_write))
    else $error("write-back not followed by its fetch");

  a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == salc_pkg::S_DIV_Q))
    else $error("accepted request did not enter the divider");

  a_hit_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salc_pkg::S_UPD && hit_r) |=> !out_valid)
    else $error("hit produced a result");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salc_pkg::S_WALK) |-> (32'(walk_r) < 32'(nw_eff)))
    else $error("way walk beyond the ways in use");

endmodule : set_assoc_lru_writeback_cache_core

`default_nettype wire

FILE: tb/cache_mem_traffic_checker.sv
// Checker for the set-associative LRU write-back cache core: keeps its own copy of the tags,
// recency ranks and geometry, predicts the memory traffic of each request and compares.
// Depends on salc_pkg for field widths, register indexes and default geometry.
`timescale 1ns / 1ps

module cache_mem_traffic_checker #(
  parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = salc_pkg::DEF_MAX_SETS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_req_type,
  input  logic [salc_pkg::BLOCK_W-1:0]   in_block_number,
  input  logic                           out_valid,
  input  logic                           out_mem_write,
  input  logic [salc_pkg::BLOCK_W-1:0]   out_mem_block,
  input  logic                           out_last,
  input  logic                           cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             pending,
  output int                             errors
);

  localparam int BW     = salc_pkg::BLOCK_W;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // Memory operation codes on out_mem_write
  localparam logic MEM_FETCH     = 1'b0;
  localparam logic MEM_WRITEBACK = 1'b1;

  typedef struct packed {
    logic          mem_write;
    logic [BW-1:0] mem_block;
    logic          last;
  } mem_op_t;

  mem_op_t mem_ops_due[$];
  int      fails = 0;

  // Shadow geometry and line store
  logic [salc_pkg::WAYS_W-1:0] ways_reg;
  logic [salc_pkg::SETS_W-1:0] sets_reg;
  logic [BW-1:0]               line_tag  [MAX_SETS][MAX_WAYS];
  bit                          line_live [MAX_SETS][MAX_WAYS];
  bit                          line_dirty[MAX_SETS][MAX_WAYS];
  logic [RANK_W-1:0]           line_rank [MAX_SETS][MAX_WAYS];

  function automatic void invalidate_lines();
    for (int s = 0; s < MAX_SETS; s++) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        line_live[s][w]  = 1'b0;
        line_dirty[s][w] = 1'b0;
        line_rank[s][w]  = '0;
      end
    end
  endfunction

  // Look the block up, update LRU state and queue the memory traffic it causes
  function automatic void predict_access(input logic wr, input logic [BW-1:0] blk);
    int unsigned       nw, ns, s, w, slot, used, oldest;
    logic [RANK_W-1:0] lim;
    bit                hit, have_free;
    nw = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
    ns = (sets_reg == 0) ? 1 : (sets_reg > MAX_SETS) ? MAX_SETS : sets_reg;
    s = (32'(blk) / nw) % ns;
    slot = 0;
    used = 0;
    oldest = 0;
    hit = 1'b0;
    have_free = 1'b0;

    // walk the ways: hit, first free way, least recent valid way
    for (w = 0; w < nw; w++) begin
      if (line_live[s][w]) begin
        used++;
        if (!hit && line_tag[s][w] == blk) begin
          hit = 1'b1;
          slot = w;
        end
        if (line_rank[s][w] >= line_rank[s][oldest] || !line_live[s][oldest])
          oldest = w;
      end else if (!have_free) begin
        have_free = 1'b1;
        if (!hit) slot = w;
      end
      if (w == 0 && !line_live[s][w]) oldest = w;
    end

    // hit: lines more recent than this one age by one, no traffic
    if (hit) begin
      lim = line_rank[s][slot];
      for (w = 0; w < nw; w++) begin
        if (line_live[s][w] && line_rank[s][w] < lim) line_rank[s][w]++;
      end
      line_rank[s][slot] = '0;
      if (wr) line_dirty[s][slot] = 1'b1;
      return;
    end

    // miss in a full set: evict least recent, writing it back if dirty
    if (used >= nw) begin
      slot = oldest;
      if (line_dirty[s][slot])
        mem_ops_due.push_back(mem_op_t'{MEM_WRITEBACK, line_tag[s][slot], 1'b0});
      line_live[s][slot] = 1'b0;
    end
    for (w = 0; w < nw; w++) begin
      if (line_live[s][w]) line_rank[s][w]++;
    end
    line_tag[s][slot]   = blk;
    line_live[s][slot]  = 1'b1;
    line_dirty[s][slot] = wr;
    line_rank[s][slot]  = '0;
    mem_ops_due.push_back(mem_op_t'{MEM_FETCH, blk, 1'b1});
  endfunction

  always @(posedge clk) begin
    mem_op_t due;
    if (!rst_n) begin
      ways_reg = salc_pkg::WAYS_W'(1);
      sets_reg = salc_pkg::SETS_W'(1);
      invalidate_lines();
      mem_ops_due.delete();
    end else begin
      // results first: a request seen at this edge cannot answer yet
      if (out_valid) begin
        if (mem_ops_due.size() == 0) begin
          $display("%0t: result with none due: mem_write %0d mem_block %0d last %0d",
                   $time, out_mem_write, out_mem_block, out_last);
          fails++;
        end else begin
          due = mem_ops_due.pop_front();
          if (out_mem_write !== due.mem_write) begin
            $display("%0t: mem_write expected %0d, got %0d", $time, due.mem_write,
                     out_mem_write);
            fails++;
          end
          if (out_mem_block !== due.mem_block) begin
            $display("%0t: mem_block expected %0d, got %0d", $time, due.mem_block,
                     out_mem_block);
            fails++;
          end
          if (out_last !== due.last) begin
            $display("%0t: last expected %0d, got %0d", $time, due.last, out_last);
            fails++;
          end
        end
      end

      // register writes drop every line, dirty or not
      if (cfg_we) begin
        case (cfg_index)
          salc_pkg::CFG_WAYS: begin
            ways_reg = cfg_wdata[salc_pkg::WAYS_W-1:0];
            invalidate_lines();
          end
          salc_pkg::CFG_SETS: begin
            sets_reg = cfg_wdata[salc_pkg::SETS_W-1:0];
            invalidate_lines();
          end
          default: ;
        endcase
      end

      if (start && !busy) predict_access(in_req_type, in_block_number);
    end
    pending <= mem_ops_due.size();
    errors  <= fails;
  end

endmodule

FILE: tb/set_assoc_lru_writeback_cache_core_tb.sv
// Testbench top for the set-associative LRU write-back cache core: clock, reset, geometry
// writes and request stimulus; checking is done by cache_mem_traffic_checker.
// Depends on salc_pkg, the core and the checker.
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_core_tb;

  localparam int BW              = salc_pkg::BLOCK_W;
  localparam int MAX_WAYS        = salc_pkg::DEF_MAX_WAYS;
  localparam int MAX_SETS        = salc_pkg::DEF_MAX_SETS;
  localparam int SETTLE_CYCLES   = 120;   // above the worst request latency
  localparam int RANDOM_REQUESTS = 1950;
  localparam int PHASES          = 12;

  // Request type codes on in_req_type
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           in_req_type = REQ_READ;
  logic [BW-1:0]                  in_block_number = '0;
  logic                           cfg_we = 1'b0;
  logic [salc_pkg::CFG_IDX_W-1:0] cfg_index = salc_pkg::CFG_WAYS;
  logic [salc_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           busy;
  logic                           out_valid;
  logic                           out_mem_write;
  logic [BW-1:0]                  out_mem_block;
  logic                           out_last;
  int                             pending;
  int                             chk_errors;

  // Stimulus shaping state
  int                             no_gap_left = 0;
  int unsigned                    eff_ways = 1;
  int unsigned                    eff_sets = 1;
  int unsigned                    hot_set = 0;
  longint unsigned                tag_base = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  set_assoc_lru_writeback_cache_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_mem_write   (out_mem_write),
    .out_mem_block   (out_mem_block),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  cache_mem_traffic_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_mem_write   (out_mem_write),
    .out_mem_block   (out_mem_block),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending         (pending),
    .errors          (chk_errors)
  );

  // Issue one request after a random gap; returns at the edge that accepts it
  task automatic issue_request(input logic wr, input logic [BW-1:0] blk);
    int gap;
    if (no_gap_left > 0) begin
      no_gap_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0) no_gap_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= wr;
    in_block_number <= blk;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until all traffic is in; the tail covers a trailing hit
  task automatic settle(input bit with_tail);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    if (with_tail) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both geometry registers; unused upper bits of the ways write are random
  task automatic apply_geometry(input int unsigned ways_val, input int unsigned sets_val);
    logic [salc_pkg::CFG_W-1:0] wd;
    longint unsigned            lim;
    wd = salc_pkg::CFG_W'($urandom);
    wd[salc_pkg::WAYS_W-1:0] = salc_pkg::WAYS_W'(ways_val);
    cfg_we <= 1'b1;
    cfg_index <= salc_pkg::CFG_WAYS;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_index <= salc_pkg::CFG_SETS;
    cfg_wdata <= salc_pkg::CFG_W'(sets_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_ways = (ways_val == 0) ? 1 : (ways_val > MAX_WAYS) ? MAX_WAYS : ways_val;
    eff_sets = (sets_val == 0) ? 1 : (sets_val > MAX_SETS) ? MAX_SETS : sets_val;
    hot_set = $urandom_range(0, eff_sets - 1);
    lim = (64'd1 << BW) / (eff_ways * eff_sets) - 3;
    tag_base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, int'(lim));
  endtask

  // Mostly blocks crowding a few sets (hits, evictions, write-backs), some noise
  function automatic logic [BW-1:0] next_block();
    longint unsigned tag, set_sel, blk;
    if ($urandom_range(0, 99) < 12) return BW'($urandom);
    tag = tag_base + $urandom_range(0, 2);
    set_sel = (hot_set + $urandom_range(0, 3)) % eff_sets;
    blk = (tag * eff_sets + set_sel) * eff_ways + $urandom_range(0, eff_ways - 1);
    return BW'(blk);
  endfunction

  initial begin
    int unsigned phase_ways[PHASES];
    int unsigned phase_sets[PHASES];
    int          per_phase;
    phase_ways = '{8, 1, 15, 0, 2, 8, 1, 5, 4, 7, 0, 0};
    phase_sets = '{256, 1, 511, 0, 3, 1, 256, 7, 300, 2, 0, 0};
    phase_ways[PHASES-2] = $urandom_range(0, 15);
    phase_sets[PHASES-2] = $urandom_range(0, 511);
    phase_ways[PHASES-1] = $urandom_range(0, 15);
    phase_sets[PHASES-1] = $urandom_range(0, 511);
    per_phase = RANDOM_REQUESTS / PHASES + 1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: a single line, every request contends for it
    issue_request(REQ_READ,  31'd0);            // fill empty set
    issue_request(REQ_READ,  31'd0);            // hit
    issue_request(REQ_WRITE, 31'd0);            // hit, line goes dirty
    issue_request(REQ_READ,  31'h7FFF_FFFF);    // dirty victim written back
    issue_request(REQ_WRITE, 31'h7FFF_FFFF);    // hit on top block
    issue_request(REQ_WRITE, 31'd5);            // dirty victim, new line dirty
    issue_request(REQ_READ,  31'd6);            // dirty victim
    issue_request(REQ_READ,  31'd7);            // clean victim
    settle(1'b1);

    // two ways, two sets: 0,1,4,5 share set 0; 2,3 and the top even block set 1
    apply_geometry(2, 2);
    issue_request(REQ_WRITE, 31'd0);            // way 0
    issue_request(REQ_READ,  31'd1);            // lowest free way, set now full
    issue_request(REQ_READ,  31'd0);            // hit, block 1 becomes least recent
    issue_request(REQ_READ,  31'd4);            // clean LRU victim
    issue_request(REQ_WRITE, 31'd5);            // dirty LRU victim
    issue_request(REQ_READ,  31'd4);            // hit
    issue_request(REQ_READ,  31'd1);            // dirty victim
    issue_request(REQ_WRITE, 31'h7FFF_FFFE);    // set 1, not full
    issue_request(REQ_READ,  31'd3);            // set 1 fills
    issue_request(REQ_READ,  31'd2);            // dirty victim in set 1
    settle(1'b1);

    // random phases over a spread of geometries, extremes and out of range included
    for (int p = 0; p < PHASES; p++) begin
      apply_geometry(phase_ways[p], phase_sets[p]);
      repeat (per_phase) begin
        issue_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, next_block());
        if ($urandom_range(0, 63) == 0) settle(1'b0);
      end
      settle(1'b1);
    end

    if (chk_errors == 0 && pending == 0) begin
      $display("** set_assoc_lru_writeback_cache_core: PASSED **");
    end else begin
      $display("** set_assoc_lru_writeback_cache_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("** set_assoc_lru_writeback_cache_core: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/salc_pkg.sv
hw/rtl/salc_ram.sv
hw/rtl/set_assoc_lru_writeback_cache_core.sv
tb/cache_mem_traffic_checker.sv
tb/set_assoc_lru_writeback_cache_core_tb.sv
